@@ src/fifo_or_max_priority_serve_table_unit_macros.svh @@
// Assertion macros for the serve table unit.
`ifndef FIFO_OR_MAX_PRIORITY_SERVE_TABLE_UNIT_MACROS_SVH
`define FIFO_OR_MAX_PRIORITY_SERVE_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define FOMPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define FOMPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define FOMPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define FOMPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/fomps_pkg.sv @@
`default_nettype none

package fomps_pkg;

    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 24;
    localparam int ID_W     = 32;
    localparam int STATUS_W = 2;

    localparam logic [OPCODE_W-1:0] OPC_ARRIVE = 2'd0;
    localparam logic [OPCODE_W-1:0] OPC_OLDEST = 2'd1;

    typedef enum logic [1:0] {
        CMD_ARRIVE,
        CMD_OLDEST,
        CMD_HIGHEST
    } t_cmd_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_SERVED = 2'd0,
        ST_STORED = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd_op              op;
        logic [VALUE_W-1:0]   value;
    } t_cmd;

    typedef struct packed {
        logic [ID_W-1:0] served_id;
        t_status         status;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ASCAN,
        S_SSCAN,
        S_SLAST,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

@@ src/fomps_ifs.sv @@
`default_nettype none

interface fomps_in_if;
    logic                              valid;
    logic                              ready;
    logic [fomps_pkg::OPCODE_W-1:0]    opcode;
    logic [fomps_pkg::VALUE_W-1:0]     priority_value;

    modport source (output valid, output opcode, output priority_value, input ready);
    modport sink   (input valid, input opcode, input priority_value, output ready);
endinterface

interface fomps_out_if;
    logic                              valid;
    logic                              ready;
    logic [fomps_pkg::ID_W-1:0]        served_id;
    logic [fomps_pkg::STATUS_W-1:0]    status;

    modport source (output valid, output served_id, output status, input ready);
    modport sink   (input valid, input served_id, input status, output ready);
endinterface

`default_nettype wire

@@ src/fomps_front.sv @@
`default_nettype none

module fomps_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    fomps_in_if.sink         i_in,
    output fomps_pkg::t_cmd  o_cmd,
    output logic             o_cmd_vld,
    input  wire logic        i_cmd_rdy
);

    localparam int QDEPTH = 2;

    fomps_pkg::t_cmd r_q [QDEPTH];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic [1:0]      n_cnt;
    fomps_pkg::t_cmd dec;
    logic            push;
    logic            pop;

    always_comb begin
        dec.value = i_in.priority_value;
        case (i_in.opcode)
            fomps_pkg::OPC_ARRIVE: dec.op = fomps_pkg::CMD_ARRIVE;
            fomps_pkg::OPC_OLDEST: dec.op = fomps_pkg::CMD_OLDEST;
            default:               dec.op = fomps_pkg::CMD_HIGHEST;
        endcase
    end

    assign i_in.ready = (r_cnt != 2'(QDEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign o_cmd_vld  = (r_cnt != 2'd0);
    assign pop        = o_cmd_vld && i_cmd_rdy;
    assign o_cmd      = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

endmodule

`default_nettype wire

@@ src/fomps_back.sv @@
`default_nettype none

module fomps_back #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire fomps_pkg::t_cmd   i_cmd,
    input  wire logic              i_cmd_vld,
    output logic                   o_cmd_rdy,
    output fomps_pkg::t_result     o_res,
    output logic                   o_res_vld,
    input  wire logic              i_res_rdy
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int OCC_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W   = fomps_pkg::ID_W;
    localparam int VAL_W  = fomps_pkg::VALUE_W;
    localparam int ENT_W  = ID_W + VAL_W;

    fomps_pkg::t_state   r_state;
    fomps_pkg::t_state   n_state;
    fomps_pkg::t_cmd_op  r_op;
    logic [VAL_W-1:0]    r_value;
    logic [IDX_W-1:0]    r_idx;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [OCC_W-1:0]    r_occ;
    logic [ID_W-1:0]     r_next_id;

    logic [ENT_W-1:0]    mem [TABLE_DEPTH];
    logic [ENT_W-1:0]    r_rd_data;
    logic                r_cmp_vld;
    logic                r_cmp_slot_vld;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic                r_best_found;
    logic [IDX_W-1:0]    r_best_idx;
    logic [ID_W-1:0]     r_best_id;
    logic [VAL_W-1:0]    r_best_val;

    logic                r_res_vld;
    fomps_pkg::t_result  r_res;

    logic                res_free;
    logic                take;
    logic                res_load;
    fomps_pkg::t_result  res_next;
    logic                do_write;
    logic                do_clear;
    logic                idx_inc;
    logic                scan_issue;
    logic                cmp_take;
    logic [ID_W-1:0]     rd_id;
    logic [VAL_W-1:0]    rd_val;
    logic                last_idx;

    assign res_free  = !r_res_vld || i_res_rdy;
    assign last_idx  = (r_idx == IDX_W'(TABLE_DEPTH - 1));
    assign rd_id     = r_rd_data[ENT_W-1:VAL_W];
    assign rd_val    = r_rd_data[VAL_W-1:0];
    assign o_res     = r_res;
    assign o_res_vld = r_res_vld;

    always_comb begin
        cmp_take = 1'b0;
        if (r_cmp_vld && r_cmp_slot_vld) begin
            if (!r_best_found) begin
                cmp_take = 1'b1;
            end else if (r_op == fomps_pkg::CMD_OLDEST) begin
                cmp_take = (rd_id < r_best_id);
            end else begin
                cmp_take = (rd_val > r_best_val) ||
                           ((rd_val == r_best_val) && (rd_id < r_best_id));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fomps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd_rdy = 1'b0;
        take      = 1'b0;
        res_load  = 1'b0;
        res_next  = '{served_id: '0, status: fomps_pkg::ST_SERVED};
        do_write  = 1'b0;
        do_clear  = 1'b0;
        idx_inc   = 1'b0;
        scan_issue = 1'b0;
        case (r_state)
            fomps_pkg::S_IDLE: begin
                o_cmd_rdy = res_free;
                if (i_cmd_vld && res_free) begin
                    take = 1'b1;
                    if (i_cmd.op == fomps_pkg::CMD_ARRIVE) begin
                        if (r_occ == OCC_W'(TABLE_DEPTH)) begin
                            res_load = 1'b1;
                            res_next = '{served_id: '0, status: fomps_pkg::ST_FULL};
                        end else begin
                            n_state = fomps_pkg::S_ASCAN;
                        end
                    end else begin
                        if (r_occ == '0) begin
                            res_load = 1'b1;
                            res_next = '{served_id: '0, status: fomps_pkg::ST_EMPTY};
                        end else begin
                            n_state = fomps_pkg::S_SSCAN;
                        end
                    end
                end
            end
            fomps_pkg::S_ASCAN: begin
                if (r_valid[r_idx]) begin
                    idx_inc = 1'b1;
                end else if (res_free) begin
                    do_write = 1'b1;
                    res_load = 1'b1;
                    res_next = '{served_id: r_next_id, status: fomps_pkg::ST_STORED};
                    n_state  = fomps_pkg::S_IDLE;
                end
            end
            fomps_pkg::S_SSCAN: begin
                scan_issue = 1'b1;
                idx_inc    = 1'b1;
                if (last_idx) begin
                    n_state = fomps_pkg::S_SLAST;
                end
            end
            fomps_pkg::S_SLAST: begin
                n_state = fomps_pkg::S_FIN;
            end
            fomps_pkg::S_FIN: begin
                if (res_free) begin
                    do_clear = 1'b1;
                    res_load = 1'b1;
                    res_next = '{served_id: r_best_id, status: fomps_pkg::ST_SERVED};
                    n_state  = fomps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fomps_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_occ        <= '0;
            r_next_id    <= ID_W'(1);
            r_res_vld    <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_best_found <= 1'b0;
        end else begin
            r_cmp_vld <= scan_issue;
            if (res_load) begin
                r_res_vld <= 1'b1;
            end else if (i_res_rdy) begin
                r_res_vld <= 1'b0;
            end
            if (do_write) begin
                r_valid[r_idx] <= 1'b1;
                r_occ          <= r_occ + OCC_W'(1);
                r_next_id      <= r_next_id + ID_W'(1);
            end
            if (do_clear) begin
                r_valid[r_best_idx] <= 1'b0;
                r_occ               <= r_occ - OCC_W'(1);
            end
            if (take) begin
                r_best_found <= 1'b0;
            end else if (cmp_take) begin
                r_best_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_op    <= i_cmd.op;
            r_value <= i_cmd.value;
            r_idx   <= '0;
        end else if (idx_inc) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (res_load) begin
            r_res <= res_next;
        end
        r_cmp_idx      <= r_idx;
        r_cmp_slot_vld <= r_valid[r_idx];
        if (cmp_take) begin
            r_best_idx <= r_cmp_idx;
            r_best_id  <= rd_id;
            r_best_val <= rd_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            mem[r_idx] <= {r_next_id, r_value};
        end
        r_rd_data <= mem[r_idx];
    end

endmodule

`default_nettype wire

@@ src/fifo_or_max_priority_serve_table_unit.sv @@
// Channel   Dir  Payload                           Transfer when
// i_in      in   opcode[1:0], priority_value[23:0] i_in.valid && i_in.ready
// o_out     out  served_id[31:0], status[1:0]      o_out.valid && o_out.ready
//
// Arrive: walks the valid bits to the lowest free slot and stores there.
// Serve: scans every slot, one slot per cycle through the table memory
// read port and one compare stage. Full arrive or empty serve: no scan.
// A two-entry command queue takes transfers while the table engine works.
// Synchronous active-low reset clears valid bits, counters and queue at once.
// A stalled o_out holds its result; the engine waits to write the next one.
`default_nettype none
`include "fifo_or_max_priority_serve_table_unit_macros.svh"

module fifo_or_max_priority_serve_table_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fomps_in_if.sink    i_in,
    fomps_out_if.source o_out
);

    fomps_pkg::t_cmd    cmd;
    logic               cmd_vld;
    logic               cmd_rdy;
    fomps_pkg::t_result res;
    logic               res_vld;
    logic               res_full;
    logic               res_empty;

    fomps_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_cmd     (cmd),
        .o_cmd_vld (cmd_vld),
        .i_cmd_rdy (cmd_rdy)
    );

    fomps_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_cmd_vld (cmd_vld),
        .o_cmd_rdy (cmd_rdy),
        .o_res     (res),
        .o_res_vld (res_vld),
        .i_res_rdy (o_out.ready)
    );

    assign o_out.valid     = res_vld;
    assign o_out.served_id = res.served_id;
    assign o_out.status    = res.status;

    assign res_full  = (res.status == fomps_pkg::ST_FULL);
    assign res_empty = (res.status == fomps_pkg::ST_EMPTY);

    `FOMPS_ASSERT_IMPLY(a_full_no_id, i_clk, i_rst_n, res_vld && res_full, res.served_id == '0)
    `FOMPS_ASSERT_IMPLY(a_empty_no_id, i_clk, i_rst_n, res_vld && res_empty, res.served_id == '0)
    `FOMPS_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, cmd_vld && cmd_rdy, !cmd_rdy || res_vld)

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;

    localparam int OPCODE_W    = fomps_pkg::OPCODE_W;
    localparam int VALUE_W     = fomps_pkg::VALUE_W;
    localparam int ID_W        = fomps_pkg::ID_W;
    localparam int TABLE_DEPTH = 64;
    localparam int NUM_ITEMS   = 600;
    localparam int NUM_ROWS    = 23;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 2 * TABLE_DEPTH + 16;
    localparam logic [OPCODE_W-1:0] OPC_SPARE = 2'd3;
    localparam logic [VALUE_W-1:0]  PRIO_MAX  = '1;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [VALUE_W-1:0]  prio;
        bit                  use_fixed;
        fomps_pkg::t_result  fixed_res;
    } t_directed_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    fomps_in_if  in_ch ();
    fomps_out_if out_ch ();

    fifo_or_max_priority_serve_table_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    bit                slot_used [TABLE_DEPTH];
    logic [ID_W-1:0]   slot_seq  [TABLE_DEPTH];
    logic [VALUE_W-1:0] slot_prio [TABLE_DEPTH];
    logic [ID_W-1:0]   seq_next;
    int                occupancy;

    fomps_pkg::t_result pending_results [$];
    int      mismatch_count;
    int      transfer_count;
    bit      burst_mode;
    bit      hold_request;

    t_directed_row directed_rows [NUM_ROWS] = '{
        '{fomps_pkg::CMD_OLDEST,  24'h000000, 1'b1, '{32'd0, fomps_pkg::ST_EMPTY}},
        '{fomps_pkg::CMD_HIGHEST, PRIO_MAX,   1'b1, '{32'd0, fomps_pkg::ST_EMPTY}},
        '{OPC_SPARE,              24'h000000, 1'b1, '{32'd0, fomps_pkg::ST_EMPTY}},
        '{fomps_pkg::CMD_ARRIVE,  24'h000000, 1'b1, '{32'd1, fomps_pkg::ST_STORED}},
        '{fomps_pkg::CMD_ARRIVE,  PRIO_MAX,   1'b1, '{32'd2, fomps_pkg::ST_STORED}},
        '{fomps_pkg::CMD_ARRIVE,  24'h800000, 1'b1, '{32'd3, fomps_pkg::ST_STORED}},
        '{fomps_pkg::CMD_ARRIVE,  PRIO_MAX,   1'b1, '{32'd4, fomps_pkg::ST_STORED}},
        '{fomps_pkg::CMD_ARRIVE,  24'h000001, 1'b1, '{32'd5, fomps_pkg::ST_STORED}},
        '{fomps_pkg::CMD_HIGHEST, 24'h000000, 1'b0, '{32'd0, fomps_pkg::ST_SERVED}},
        '{OPC_SPARE,              24'h123456, 1'b0, '{32'd0, fomps_pkg::ST_SERVED}},
        '{fomps_pkg::CMD_OLDEST,  PRIO_MAX,   1'b0, '{32'd0, fomps_pkg::ST_SERVED}},
        '{fomps_pkg::CMD_ARRIVE,  24'h555555, 1'b0, '{32'd0, fomps_pkg::ST_SERVED}},
        '{fomps_pkg::CMD_ARRIVE,  24'hAAAAAA, 1'b0, '{32'd0, fomps_pkg::ST_SERVED}},
        '{fomps_pkg::CMD_HIGHEST, 24'h000000, 1'b0, '{32'd0, fomps_pkg::ST_SERVED}},
        '{fomps_pkg::CMD_OLDEST,  24'h000000, 1'b0, '{32'd0, fomps_pkg::ST_SERVED}},
        '{fomps_pkg::CMD_OLDEST,  24'h000000, 1'b0, '{32'd0, fomps_pkg::ST_SERVED}},
        '{fomps_pkg::CMD_OLDEST,  24'h000000, 1'b0, '{32'd0, fomps_pkg::ST_SERVED}},
        '{fomps_pkg::CMD_OLDEST,  24'h000000, 1'b0, '{32'd0, fomps_pkg::ST_SERVED}},
        '{fomps_pkg::CMD_HIGHEST, 24'h000000, 1'b0, '{32'd0, fomps_pkg::ST_SERVED}},
        '{fomps_pkg::CMD_ARRIVE,  24'h000000, 1'b0, '{32'd0, fomps_pkg::ST_SERVED}},
        '{fomps_pkg::CMD_ARRIVE,  24'h000000, 1'b0, '{32'd0, fomps_pkg::ST_SERVED}},
        '{fomps_pkg::CMD_HIGHEST, 24'h000000, 1'b0, '{32'd0, fomps_pkg::ST_SERVED}},
        '{fomps_pkg::CMD_HIGHEST, 24'h000000, 1'b0, '{32'd0, fomps_pkg::ST_SERVED}}
    };

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic fomps_pkg::t_result apply_command(logic [OPCODE_W-1:0] op,
                                                         logic [VALUE_W-1:0] prio);
        int                 pick;
        fomps_pkg::t_result res;
        pick = -1;
        if (op == fomps_pkg::CMD_ARRIVE) begin
            for (int s = 0; s < TABLE_DEPTH; s++) begin
                if (!slot_used[s] && pick < 0) pick = s;
            end
            if (pick < 0) begin
                res = '{'0, fomps_pkg::ST_FULL};
            end else begin
                slot_used[pick] = 1'b1;
                slot_seq[pick]  = seq_next;
                slot_prio[pick] = prio;
                res = '{seq_next, fomps_pkg::ST_STORED};
                seq_next = seq_next + ID_W'(1);
                occupancy++;
            end
            return res;
        end
        for (int s = 0; s < TABLE_DEPTH; s++) begin
            if (slot_used[s]) begin
                if (pick < 0) begin
                    pick = s;
                end else if (op == fomps_pkg::CMD_OLDEST) begin
                    if (slot_seq[s] < slot_seq[pick]) pick = s;
                end else if (slot_prio[s] > slot_prio[pick] ||
                             (slot_prio[s] == slot_prio[pick] &&
                              slot_seq[s] < slot_seq[pick])) begin
                    pick = s;
                end
            end
        end
        if (pick < 0) begin
            res = '{'0, fomps_pkg::ST_EMPTY};
        end else begin
            slot_used[pick] = 1'b0;
            occupancy--;
            res = '{slot_seq[pick], fomps_pkg::ST_SERVED};
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst_mode) return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_prio();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return PRIO_MAX;
            2, 3, 4: return VALUE_W'($urandom_range(0, 7));
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    function automatic logic [OPCODE_W-1:0] pick_serve_op();
        case ($urandom_range(0, 4))
            0, 1: return fomps_pkg::CMD_OLDEST;
            2, 3: return fomps_pkg::CMD_HIGHEST;
            default: return OPC_SPARE;
        endcase
    endfunction

    task automatic note_mismatch(string what, logic [ID_W-1:0] exp_v,
                                 logic [ID_W-1:0] act_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %0d at %0t: %s expected %h got %h",
                     mismatch_count, $realtime, what, exp_v, act_v);
    endtask

    task automatic send_cmd(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] prio,
                            bit use_fixed, fomps_pkg::t_result fixed_res);
        int                 gap;
        fomps_pkg::t_result predicted;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid          = 1'b1;
        in_ch.opcode         = op;
        in_ch.priority_value = prio;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predicted = apply_command(op, prio);
        pending_results.insert(pending_results.size(), use_fixed ? fixed_res : predicted);
        transfer_count++;
        @(negedge i_clk);
    endtask

    task automatic send_random(bit arrive);
        send_cmd(arrive ? fomps_pkg::CMD_ARRIVE : pick_serve_op(), pick_prio(), 1'b0, '0);
    endtask

    always @(posedge i_clk) begin : result_check
        fomps_pkg::t_result exp_res;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result, served_id", '0, out_ch.served_id);
            end else begin
                exp_res = pending_results.pop_front();
                if (out_ch.served_id !== exp_res.served_id)
                    note_mismatch("served_id", exp_res.served_id, out_ch.served_id);
                if (out_ch.status !== exp_res.status)
                    note_mismatch("status", ID_W'(exp_res.status), ID_W'(out_ch.status));
            end
        end
    end

    initial begin : receiver
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left--;
            end else if (!burst_mode && $urandom_range(0, 3) == 0) begin
                out_ch.ready = 1'b0;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(0, 2);
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    initial begin : watchdog
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int  phase_kind;
        int  wait_cycles;
        bit  pressure_done;
        in_ch.valid          = 1'b0;
        in_ch.opcode         = fomps_pkg::CMD_ARRIVE;
        in_ch.priority_value = '0;
        burst_mode     = 1'b0;
        hold_request   = 1'b0;
        pressure_done  = 1'b0;
        mismatch_count = 0;
        transfer_count = 0;
        for (int s = 0; s < TABLE_DEPTH; s++) begin
            slot_used[s] = 1'b0;
            slot_seq[s]  = '0;
            slot_prio[s] = '0;
        end
        seq_next  = ID_W'(1);
        occupancy = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i])
            send_cmd(directed_rows[i].op, directed_rows[i].prio,
                     directed_rows[i].use_fixed, directed_rows[i].fixed_res);

        while (transfer_count < NUM_ITEMS) begin
            burst_mode = ($urandom_range(0, 4) == 0);
            phase_kind = $urandom_range(0, 9);
            if (!pressure_done && transfer_count > 150) begin
                // stall the output long enough for the input side to back up
                pressure_done = 1'b1;
                burst_mode    = 1'b1;
                hold_request  = 1'b1;
                repeat (16) send_random($urandom_range(0, 3) != 0);
            end else if (phase_kind < 3) begin
                while (occupancy < TABLE_DEPTH)
                    send_random($urandom_range(0, 9) != 0);
                repeat ($urandom_range(1, 4)) send_random(1'b1);
            end else if (phase_kind < 6) begin
                while (occupancy > 0)
                    send_random(1'b0);
                repeat ($urandom_range(1, 3)) send_random(1'b0);
            end else begin
                repeat ($urandom_range(20, 40)) send_random($urandom_range(0, 1) == 1);
            end
        end
        in_ch.valid = 1'b0;
        burst_mode  = 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        wait_cycles = DRAIN_WAIT;
        repeat (wait_cycles) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ fifo_or_max_priority_serve_table_unit.f @@
+incdir+src
src/fomps_pkg.sv
src/fomps_ifs.sv
src/fomps_front.sv
src/fomps_back.sv
src/fifo_or_max_priority_serve_table_unit.sv
dv/tb.sv
